// ===== rtl/wss_pkg.sv =====
// Shared types and constants of the windowed substring search.
// Used by wss_cfg, wss_cell and windowed_substring_search; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package wss_pkg;

	// Pattern storage fixed by the two 64-bit pattern registers.
	localparam int unsigned PAT_BYTES = 16;
	localparam int unsigned PLEN_W    = 5;
	localparam int unsigned PIDX_W    = 4;
	localparam int unsigned POS_W     = 17;
	localparam int unsigned WSTART_W  = 16;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 64;

	// Letter folding bounds: fold 'A'..'Z' only.
	localparam logic [7:0] FOLD_BELOW = 8'd64;
	localparam logic [7:0] FOLD_ABOVE = 8'd91;
	localparam logic [7:0] FOLD_OFS   = 8'd32;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CASE_SENSITIVE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_REVERSE_SEARCH = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_START   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_END     = 3'd6;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       last_byte;
	} in_word_t;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] match_position;
		logic [POS_W-1:0] text_length;
	} out_word_t;

	typedef logic [PAT_BYTES-1:0][7:0] pat_bytes_t;

	typedef struct packed {
		pat_bytes_t          pat;
		logic [PLEN_W-1:0]   pat_len;
		logic                case_sens;
		logic                reverse;
		logic [WSTART_W-1:0] win_start;
		logic [POS_W-1:0]    win_end;
	} wss_cfg_t;

	typedef struct packed {
		logic in_use;
		logic is_first;
		logic fold_en;
	} cell_ctl_t;

	typedef struct packed {
		logic eq;
		logic stop;
	} cell_flags_t;

	function automatic logic [7:0] fold(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c > FOLD_BELOW && c < FOLD_ABOVE) begin
			r = c + FOLD_OFS;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/wss_cfg.sv =====
// Configuration register file of the substring search.
// Depends on wss_pkg for register indexes and the wss_cfg_t bundle.
`timescale 1ns / 1ps
`default_nettype none

module wss_cfg (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              wr_en,
	input  wire logic [wss_pkg::CFG_IDX_W-1:0]     wr_index,
	input  wire logic [wss_pkg::CFG_DATA_W-1:0]    wr_data,
	output wss_pkg::wss_cfg_t                      cfg
);

	wss_pkg::wss_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pat       <= '0;
			cfg_q.pat_len   <= wss_pkg::PLEN_W'(1);
			cfg_q.case_sens <= 1'b1;
			cfg_q.reverse   <= 1'b0;
			cfg_q.win_start <= '0;
			cfg_q.win_end   <= wss_pkg::POS_W'(65536);
		end else if (wr_en) begin
			case (wr_index)
				wss_pkg::REG_PATTERN_LOW: begin
					cfg_q.pat[7:0] <= wr_data;
				end
				wss_pkg::REG_PATTERN_HIGH: begin
					cfg_q.pat[15:8] <= wr_data;
				end
				wss_pkg::REG_PATTERN_LENGTH: begin
					cfg_q.pat_len <= wr_data[wss_pkg::PLEN_W-1:0];
				end
				wss_pkg::REG_CASE_SENSITIVE: begin
					cfg_q.case_sens <= wr_data[0];
				end
				wss_pkg::REG_REVERSE_SEARCH: begin
					cfg_q.reverse <= wr_data[0];
				end
				wss_pkg::REG_WINDOW_START: begin
					cfg_q.win_start <= wr_data[wss_pkg::WSTART_W-1:0];
				end
				wss_pkg::REG_WINDOW_END: begin
					cfg_q.win_end <= wr_data[wss_pkg::POS_W-1:0];
				end
				default: begin
					// unknown index: drop the word
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/wss_cell.sv =====
// One cell of the text shift chain: holds a byte and compares the byte entering it with its pattern byte.
// Depends on wss_pkg for the fold function and the cell control and flag structs.
`timescale 1ns / 1ps
`default_nettype none

module wss_cell (
	input  wire logic          clk,
	input  wire logic          shift_en,
	input  wire logic [7:0]    byte_in,
	input  wire logic [7:0]    exp_byte,
	input  wire wss_pkg::cell_ctl_t ctl,
	output logic [7:0]         byte_q,
	output wss_pkg::cell_flags_t flags
);

	logic [7:0] txt_c;
	logic [7:0] pat_c;

	// Compare the byte that enters this cell on the current shift.
	always_comb begin
		txt_c = ctl.fold_en ? wss_pkg::fold(byte_in) : byte_in;
		pat_c = ctl.fold_en ? wss_pkg::fold(exp_byte) : exp_byte;
		flags.eq   = !ctl.in_use || (txt_c == pat_c);
		flags.stop = ctl.is_first && ((byte_in == 8'd0) || byte_in[7]);
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			byte_q <= byte_in;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/windowed_substring_search.sv =====
// Windowed substring search over a byte stream.
// Text words enter on in_valid/in_ready, one byte each, the final byte marked by
// last_byte. A byte at position MAX_TEXT-1 ends the text whatever its mark says.
// Configuration words enter on cfg_valid/cfg_ready (always ready), index and data;
// write them only between texts.
// One result word leaves on out_valid/out_ready per text: found, start of the
// match (or the text length if none) and the text length.
// Throughput: one byte per cycle. A row of MAX_PATTERN cells holds the newest
// bytes and compares them in parallel; the hit state updates in the same cycle.
// The result is registered and shows in the cycle after the final byte is taken.
// If the receiver stalls, non-final bytes are still taken; a final byte waits
// only while the previous result has not been taken.
// Reset clears the registers to their reset values and all per-text state;
// the block is ready as soon as reset is released.
`timescale 1ns / 1ps
`default_nettype none

module windowed_substring_search #(
	parameter int unsigned MAX_PATTERN = 16,
	parameter int unsigned MAX_TEXT    = 65536
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire wss_pkg::in_word_t              in_word,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output wss_pkg::out_word_t                  out_word,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [wss_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [wss_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int unsigned CW = $clog2(MAX_TEXT + 1);
	localparam int unsigned XW = ((CW > wss_pkg::POS_W) ? CW : wss_pkg::POS_W) + 1;

	wss_pkg::wss_cfg_t cfg;

	logic [CW-1:0] count_q;
	logic          hit_q;
	logic [CW-1:0] hit_pos_q;
	logic          halted_q;

	logic               out_valid_q;
	wss_pkg::out_word_t out_word_q;

	logic [wss_pkg::PLEN_W-1:0] plen;
	logic [CW-1:0]  n;
	logic           force_last;
	logic           produce;
	logic           accept;
	logic           cand;
	logic [XW-1:0]  n_x;
	logic [XW-1:0]  plen_x;
	logic           all_eq;
	logic           any_stop;
	logic           hit_nx;
	logic [CW-1:0]  hit_pos_nx;
	logic           halted_nx;

	logic [MAX_PATTERN-1:0][7:0] cell_byte;
	wss_pkg::cell_flags_t [MAX_PATTERN-1:0] cell_flags;
	logic [MAX_PATTERN-1:0] eq_vec;
	logic [MAX_PATTERN-1:0] stop_vec;

	assign cfg_ready = 1'b1;

	wss_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Clamp oversized lengths to the chain length.
	always_comb begin
		if (cfg.pat_len > wss_pkg::PLEN_W'(MAX_PATTERN)) begin
			plen = wss_pkg::PLEN_W'(MAX_PATTERN);
		end else begin
			plen = cfg.pat_len;
		end
	end

	assign force_last = count_q >= CW'(MAX_TEXT - 1);
	assign produce    = in_word.last_byte || force_last;
	assign in_ready   = !out_valid_q || out_ready || !produce;
	assign accept     = in_valid && in_ready;

	for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_chain
		wss_pkg::cell_ctl_t ctl;
		logic [7:0] src;
		logic [wss_pkg::PIDX_W-1:0] pidx;

		if (k == 0) begin : g_head
			assign src = in_word.text_byte;
		end else begin : g_link
			assign src = cell_byte[k-1];
		end

		// Cell k sits under pattern byte plen-1-k of the candidate ending here.
		always_comb begin
			pidx = wss_pkg::PIDX_W'(plen - wss_pkg::PLEN_W'(k) - wss_pkg::PLEN_W'(1));
			ctl.in_use   = wss_pkg::PLEN_W'(k) < plen;
			ctl.is_first = (wss_pkg::PLEN_W'(k) + wss_pkg::PLEN_W'(1)) == plen;
			ctl.fold_en  = !cfg.case_sens;
		end

		wss_cell u_cell (
			.clk      (clk),
			.shift_en (accept),
			.byte_in  (src),
			.exp_byte (cfg.pat[pidx]),
			.ctl      (ctl),
			.byte_q   (cell_byte[k]),
			.flags    (cell_flags[k])
		);

		assign eq_vec[k]   = cell_flags[k].eq;
		assign stop_vec[k] = cell_flags[k].stop;
	end

	always_comb begin
		n        = count_q + CW'(1);
		n_x      = XW'(n);
		plen_x   = XW'(plen);
		all_eq   = &eq_vec;
		any_stop = |stop_vec;
		cand = (plen != '0) && (n_x >= plen_x)
			&& (n_x >= XW'(cfg.win_start) + plen_x)
			&& (n_x <= XW'(cfg.win_end));

		hit_nx     = hit_q;
		hit_pos_nx = hit_pos_q;
		halted_nx  = halted_q;
		if (cand && (cfg.reverse || (!hit_q && !halted_q))) begin
			if (!cfg.reverse && any_stop) begin
				halted_nx = 1'b1;
			end else if (all_eq) begin
				hit_nx     = 1'b1;
				hit_pos_nx = n - CW'(plen);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			hit_q    <= 1'b0;
			halted_q <= 1'b0;
		end else if (accept) begin
			if (produce) begin
				count_q  <= '0;
				hit_q    <= 1'b0;
				halted_q <= 1'b0;
			end else begin
				count_q  <= n;
				hit_q    <= hit_nx;
				halted_q <= halted_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hit_pos_q <= hit_pos_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && produce) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && produce) begin
			out_word_q.found          <= hit_nx;
			out_word_q.match_position <= wss_pkg::POS_W'(hit_nx ? hit_pos_nx : n);
			out_word_q.text_length    <= wss_pkg::POS_W'(n);
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking bench for windowed_substring_search: a scoreboard class predicts
// each text's result from the byte stream and the register writes it has seen.
// Depends on rtl/wss_pkg.sv and rtl/windowed_substring_search.sv.
`timescale 1ns / 1ps

module tb_top;

	localparam int unsigned HALF_PERIOD = 4;
	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int unsigned TEXT_CAP    = 65536;
	localparam int unsigned PHASE_BYTES = 125;

	// An index with no register behind it.
	localparam logic [wss_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	class match_scoreboard;
		logic [15:0][7:0] pat;
		logic [4:0]       plen_r;
		bit               cs_r;
		bit               rev_r;
		logic [15:0]      ws_r;
		logic [16:0]      we_r;

		logic [7:0]  recent[16];
		int unsigned count;
		bit          hit_seen;
		int unsigned hit_pos;
		bit          halted;

		wss_pkg::out_word_t expected_q[$];
		int unsigned items;
		int unsigned errors;

		function void clear_text();
			foreach (recent[i]) recent[i] = 8'h00;
			count    = 0;
			hit_seen = 0;
			hit_pos  = 0;
			halted   = 0;
		endfunction

		function void reset_all();
			pat     = '0;
			plen_r  = 5'd1;
			cs_r    = 1'b1;
			rev_r   = 1'b0;
			ws_r    = '0;
			we_r    = 17'h10000;
			items   = 0;
			errors  = 0;
			clear_text();
		endfunction

		function logic [7:0] fold_az(logic [7:0] c);
			return (c >= "A" && c <= "Z") ? c + 8'h20 : c;
		endfunction

		function void write_reg(logic [wss_pkg::CFG_IDX_W-1:0] idx,
				logic [wss_pkg::CFG_DATA_W-1:0] d);
			case (idx)
				wss_pkg::REG_PATTERN_LOW:    pat[7:0]  = d;
				wss_pkg::REG_PATTERN_HIGH:   pat[15:8] = d;
				wss_pkg::REG_PATTERN_LENGTH: plen_r    = d[4:0];
				wss_pkg::REG_CASE_SENSITIVE: cs_r      = d[0];
				wss_pkg::REG_REVERSE_SEARCH: rev_r     = d[0];
				wss_pkg::REG_WINDOW_START:   ws_r      = d[15:0];
				wss_pkg::REG_WINDOW_END:     we_r      = d[16:0];
				default: ;
			endcase
		endfunction

		function void note_byte(logic [7:0] b, bit last);
			int unsigned pos;
			int unsigned plen;
			int unsigned s;
			bit          fin;
			bit          eq;
			logic [7:0]  first;
			logic [7:0]  t;
			logic [7:0]  p;
			wss_pkg::out_word_t want;
			items++;
			pos  = count;
			plen = (plen_r > 16) ? 16 : plen_r;
			fin  = last || (pos >= TEXT_CAP - 1);
			for (int k = 15; k > 0; k--) recent[k] = recent[k-1];
			recent[0] = b;
			if (plen > 0 && pos + 1 >= plen) begin
				s = pos + 1 - plen;
				if (s >= ws_r && pos + 1 <= we_r && (rev_r || (!hit_seen && !halted))) begin
					first = recent[plen-1];
					// a start byte that is zero or has the top bit set ends a forward scan
					if (!rev_r && (first == 8'h00 || first[7])) begin
						halted = 1;
					end else begin
						eq = 1;
						for (int i = 0; i < plen && eq; i++) begin
							t = recent[plen-1-i];
							p = pat[i];
							if (!cs_r) begin
								t = fold_az(t);
								p = fold_az(p);
							end
							if (t != p) eq = 0;
						end
						if (eq) begin
							hit_seen = 1;
							hit_pos  = s;
						end
					end
				end
			end
			count = pos + 1;
			if (fin) begin
				want.found          = hit_seen;
				want.match_position = hit_seen ? wss_pkg::POS_W'(hit_pos)
					: wss_pkg::POS_W'(count);
				want.text_length    = wss_pkg::POS_W'(count);
				expected_q.push_back(want);
				clear_text();
			end
		endfunction

		function void check_result(wss_pkg::out_word_t got);
			wss_pkg::out_word_t want;
			if (expected_q.size() == 0) begin
				$error("result word with none expected: found %0d position %0d length %0d",
					got.found, got.match_position, got.text_length);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (got.found !== want.found) begin
				$error("found: expected %0d, got %0d", want.found, got.found);
				errors++;
			end
			if (got.match_position !== want.match_position) begin
				$error("match_position: expected %0d, got %0d",
					want.match_position, got.match_position);
				errors++;
			end
			if (got.text_length !== want.text_length) begin
				$error("text_length: expected %0d, got %0d", want.text_length, got.text_length);
				errors++;
			end
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction
	endclass

	logic                           clk;
	logic                           arst_n;
	logic                           in_valid;
	logic                           in_ready;
	wss_pkg::in_word_t              in_word;
	logic                           out_valid;
	logic                           out_ready;
	wss_pkg::out_word_t             out_word;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [wss_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [wss_pkg::CFG_DATA_W-1:0] cfg_data;

	match_scoreboard sb;
	int unsigned     send_idle;
	int unsigned     recv_stall;
	int unsigned     cycle_count;
	int unsigned     send_idle_tab[4]  = '{0, 64, 0, 9};
	int unsigned     recv_stall_tab[4] = '{0, 0, 64, 9};

	windowed_substring_search u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #(HALF_PERIOD) clk = ~clk;

	always @(negedge clk) begin
		out_ready = ($urandom_range(99) >= recv_stall);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_result(out_word);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	function automatic logic [7:0] rand_letter();
		logic [7:0] c;
		c = "a" + 8'($urandom_range(25));
		return $urandom_range(1) ? c - 8'h20 : c;
	endfunction

	function automatic logic [7:0] flip_case(logic [7:0] c, bit en);
		if (en && ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z"))) return c ^ 8'h20;
		return c;
	endfunction

	// Keep the field value in the low bits, junk above it half of the time.
	function automatic logic [wss_pkg::CFG_DATA_W-1:0] with_junk(
			logic [wss_pkg::CFG_DATA_W-1:0] v, int w);
		logic [wss_pkg::CFG_DATA_W-1:0] d;
		if ($urandom_range(1)) return v;
		d = {$urandom, $urandom};
		return ((d >> w) << w) | v;
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_byte(logic [7:0] b, bit last);
		while ($urandom_range(99) < send_idle) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_word  = '{text_byte: b, last_byte: last};
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_byte(b, last);
		@(negedge clk);
	endtask

	// Drain all results first: registers change only between texts.
	task automatic write_reg(logic [wss_pkg::CFG_IDX_W-1:0] idx,
			logic [wss_pkg::CFG_DATA_W-1:0] d);
		in_valid = 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (3) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.write_reg(idx, d);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic load_pattern(string s);
		logic [15:0][7:0] p;
		p = '0;
		for (int i = 0; i < s.len() && i < 16; i++) p[i] = s[i];
		write_reg(wss_pkg::REG_PATTERN_LOW, p[7:0]);
		write_reg(wss_pkg::REG_PATTERN_HIGH, p[15:8]);
	endtask

	task automatic send_str(string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
	endtask

	task automatic random_config();
		logic [15:0][7:0] p;
		int unsigned      r;
		int unsigned      v;
		for (int i = 0; i < 16; i++)
			p[i] = ($urandom_range(7) == 0) ? 8'($urandom_range(255)) : rand_letter();
		write_reg(wss_pkg::REG_PATTERN_LOW, p[7:0]);
		write_reg(wss_pkg::REG_PATTERN_HIGH, p[15:8]);
		r = $urandom_range(99);
		if (r < 5)       v = 0;
		else if (r < 10) v = $urandom_range(17, 31);
		else if (r < 20) v = 16;
		else             v = $urandom_range(1, 6);
		write_reg(wss_pkg::REG_PATTERN_LENGTH, with_junk(v, wss_pkg::PLEN_W));
		if ($urandom_range(1))
			write_reg(wss_pkg::REG_CASE_SENSITIVE, with_junk($urandom_range(1), 1));
		if ($urandom_range(1))
			write_reg(wss_pkg::REG_REVERSE_SEARCH, with_junk($urandom_range(1), 1));
		if ($urandom_range(2) == 0) begin
			r = $urandom_range(99);
			if (r < 70)      v = 0;
			else if (r < 90) v = $urandom_range(1, 8);
			else if (r < 95) v = 16'hFFFF;
			else             v = $urandom_range(16'hFFFF);
			write_reg(wss_pkg::REG_WINDOW_START, with_junk(v, wss_pkg::WSTART_W));
		end
		if ($urandom_range(2) == 0) begin
			r = $urandom_range(99);
			if (r < 60)      v = 17'h10000;
			else if (r < 80) v = $urandom_range(0, 40);
			else if (r < 90) v = 17'h1FFFF;
			else if (r < 95) v = 0;
			else             v = $urandom_range(17'h1FFFF);
			write_reg(wss_pkg::REG_WINDOW_END, with_junk(v, wss_pkg::POS_W));
		end
	endtask

	// Mostly text built from pattern bytes with planted, case-flipped and
	// partial copies; now and then pure noise.
	task automatic random_text();
		logic [7:0]  txt[$];
		logic [7:0]  c;
		int unsigned n;
		int unsigned plen;
		int unsigned at;
		int unsigned cut;
		int unsigned r;
		bit          noise;
		plen  = (sb.plen_r > 16) ? 16 : sb.plen_r;
		n     = ($urandom_range(9) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 24);
		noise = ($urandom_range(4) == 0);
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (noise)                  c = 8'($urandom_range(255));
			else if (r < 60 && plen > 0) c = flip_case(sb.pat[$urandom_range(plen - 1)],
					$urandom_range(3) == 0);
			else if (r < 88)            c = rand_letter();
			else if (r < 92)            c = 8'h00;
			else                        c = 8'($urandom_range(255));
			txt.push_back(c);
		end
		if (!noise && plen > 0 && n >= plen) begin
			repeat ($urandom_range(2)) begin
				at  = $urandom_range(n - plen);
				cut = ($urandom_range(4) == 0) ? $urandom_range(plen) : plen;
				for (int j = 0; j < cut; j++)
					txt[at + j] = flip_case(sb.pat[j], $urandom_range(7) == 0);
			end
		end
		for (int i = 0; i < n; i++) send_byte(txt[i], i == n - 1);
	endtask

	initial begin
		int unsigned target;
		sb = new;
		sb.reset_all();
		clk         = 1'b0;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		in_word     = '0;
		out_ready   = 1'b0;
		cfg_valid   = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		send_idle   = 0;
		recv_stall  = 0;
		cycle_count = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset pattern is a single zero byte: a zero start halts the forward scan
		send_byte(8'h00, 1'b1);
		write_reg(REG_UNUSED, {$urandom, $urandom});
		load_pattern("Ab");
		write_reg(wss_pkg::REG_PATTERN_LENGTH, 2);
		write_reg(wss_pkg::REG_CASE_SENSITIVE, 0);
		send_str("xaBab");
		write_reg(wss_pkg::REG_REVERSE_SEARCH, 1);
		send_str("aBab");
		write_reg(wss_pkg::REG_CASE_SENSITIVE, 1);
		write_reg(wss_pkg::REG_REVERSE_SEARCH, 0);
		send_byte(8'hFF, 1'b0);
		send_str("Ab");
		// empty pattern never matches
		write_reg(wss_pkg::REG_PATTERN_LENGTH, 0);
		send_str("Ab");
		// oversized length acts as the full sixteen bytes
		load_pattern("0123456789abcdef");
		write_reg(wss_pkg::REG_PATTERN_LENGTH, 31);
		send_str("0123456789abcdef");
		load_pattern("z");
		write_reg(wss_pkg::REG_PATTERN_LENGTH, 1);
		write_reg(wss_pkg::REG_WINDOW_END, 17'h1FFFF);
		// window starts too late for any candidate
		write_reg(wss_pkg::REG_WINDOW_START, 16'hFFFF);
		send_str("zz");
		write_reg(wss_pkg::REG_WINDOW_START, 0);

		for (int ph = 0; ph < 4; ph++) begin
			send_idle  = send_idle_tab[ph];
			recv_stall = recv_stall_tab[ph];
			target     = sb.items + PHASE_BYTES;
			while (sb.items < target) begin
				if ($urandom_range(2) == 0) random_config();
				random_text();
			end
		end

		in_valid = 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		if (sb.errors == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

endmodule
